/* sv/irqpk_pkg.sv */
package irqpk_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned BitW       = 5;
  localparam int unsigned VecW       = 9;
  localparam int unsigned LimitW     = 12;
  localparam logic [LimitW-1:0] LimitReset = 12'd512;

  localparam logic ActRaise = 1'b0;
  localparam logic ActClaim = 1'b1;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StSpurious  = 2'd1,
    StEmptyWord = 2'd2,
    StOverLimit = 2'd3
  } status_e;

  typedef logic [WordBits-1:0] word_t;

endpackage

/* sv/irqpk_req_if.sv */
interface irqpk_req_if import irqpk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [VecW-1:0] vector_in;

  modport source (output valid, action, vector_in, input ready);
  modport sink   (input valid, action, vector_in, output ready);
endinterface

/* sv/irqpk_rsp_if.sv */
interface irqpk_rsp_if import irqpk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [VecW-1:0] vector_out;
  logic            more_pending;
  status_e         status;

  modport source (output valid, found, vector_out, more_pending, status, input ready);
  modport sink   (input valid, found, vector_out, more_pending, status, output ready);
endinterface

/* sv/two_level_pending_irq_picker.sv */
// Two-level pending interrupt picker. A raise beat marks vector_in pending in its
// group word and sets the group's summary bit; a claim beat returns the lowest pending
// vector (lowest summary group, then lowest bit in that word), clears it, and reports
// whether anything stays pending. The group words live in a single-port memory with a
// registered read: the accept cycle reads the word, and the RMW state, once the output
// is free, modifies it, writes it back and loads the result register. One beat is in
// flight at a time; a new beat is taken while the previous result still waits at the
// output. Per-word valid bits replace a memory clear, so the block is ready right after
// reset. Write vector_limit via cfg_we_i/cfg_wdata_i only while idle; not enforced here.
module two_level_pending_irq_picker import irqpk_pkg::*; #(
  parameter int unsigned GROUPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  irqpk_req_if.sink         req_i,
  irqpk_rsp_if.source       rsp_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  localparam int unsigned GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned VecFW = GW + BitW;

  typedef enum logic {StIdle, StRmw} state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic              found_q;
  logic [VecW-1:0]   vector_out_q;
  logic              more_q;
  status_e           status_q;

  word_t             pend_mem_q [GROUPS];
  word_t             rdata_q;
  logic              rvalid_q;
  logic [GROUPS-1:0] wvalid_q;
  logic [GROUPS-1:0] summary_q, summary_d;
  logic [LimitW-1:0] limit_q;

  logic              act_q;
  logic [BitW-1:0]   bit_sel_q;
  logic [GW-1:0]     grp_q, grp_d;
  logic              raise_ok_q, raise_ok_d;

  logic              accept, finish;
  word_t             word, word_new;
  logic [BitW-1:0]   bit_idx;
  logic [VecFW-1:0]  vec;
  logic              we;
  logic              found_d, more_d;
  logic [VecW-1:0]   vec_out_d;
  status_e           status_d;

  function automatic logic [GW-1:0] lowest_grp(input logic [GROUPS-1:0] s);
    logic [GW-1:0] idx;
    idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (s[i]) idx = GW'(i);
    end
    return idx;
  endfunction

  function automatic logic [BitW-1:0] lowest_bit(input word_t w);
    logic [BitW-1:0] idx;
    idx = '1;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) idx = BitW'(i);
    end
    return idx;
  endfunction

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign finish      = (state_q == StRmw) && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.vector_out   = vector_out_q;
  assign rsp_o.more_pending = more_q;
  assign rsp_o.status       = status_q;

  // group select at accept
  always_comb begin
    raise_ok_d = (32'(req_i.vector_in[VecW-1:BitW]) < GROUPS);
    if (req_i.action == ActClaim) begin
      grp_d = lowest_grp(summary_q);
    end else begin
      grp_d = GW'(req_i.vector_in[VecW-1:BitW]);
    end
  end

  // modify stage
  always_comb begin
    word      = rvalid_q ? rdata_q : '0;
    bit_idx   = lowest_bit(word);
    word_new  = word;
    summary_d = summary_q;
    we        = 1'b0;
    found_d   = 1'b0;
    more_d    = 1'b0;
    vec_out_d = '0;
    status_d  = StOk;
    vec       = {grp_q, bit_idx};
    if (act_q == ActRaise) begin
      if (raise_ok_q) begin
        word_new         = word | (word_t'(1) << bit_sel_q);
        we               = 1'b1;
        summary_d[grp_q] = 1'b1;
      end
    end else if (summary_q == '0) begin
      status_d = StSpurious;
    end else if (word == '0) begin
      status_d = StEmptyWord;
    end else begin
      word_new = word & ~(word_t'(1) << bit_idx);
      we       = 1'b1;
      if (word_new == '0) summary_d[grp_q] = 1'b0;
      more_d = (summary_d != '0);
      if (LimitW'(vec) >= limit_q) begin
        status_d = StOverLimit;
      end else begin
        found_d   = 1'b1;
        vec_out_d = VecW'(vec);
      end
    end
  end

  // word memory
  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= pend_mem_q[grp_d];
    if (finish && we) pend_mem_q[grp_q] <= word_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q  <= '0;
      wvalid_q   <= '0;
      limit_q    <= LimitReset;
      rvalid_q   <= 1'b0;
      act_q      <= ActRaise;
      bit_sel_q  <= '0;
      grp_q      <= '0;
      raise_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (accept) begin
        rvalid_q   <= wvalid_q[grp_d];
        act_q      <= req_i.action;
        bit_sel_q  <= req_i.vector_in[BitW-1:0];
        grp_q      <= grp_d;
        raise_ok_q <= raise_ok_d;
      end
      if (finish) begin
        summary_q <= summary_d;
        if (we) wvalid_q[grp_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      vector_out_q <= '0;
      more_q       <= 1'b0;
      status_q     <= StOk;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (rsp_o.ready) out_valid_q <= 1'b0;
          if (accept) state_q <= StRmw;
        end
        StRmw: begin
          if (finish) begin
            state_q      <= StIdle;
            out_valid_q  <= 1'b1;
            found_q      <= found_d;
            vector_out_q <= vec_out_d;
            more_q       <= more_d;
            status_q     <= status_d;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_summary_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (summary_q & ~wvalid_q) == '0)
    else $error("summary bit set for a word never written");

  a_more_matches_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && act_q == ActClaim |=> rsp_o.more_pending == (summary_q != '0)
      || rsp_o.status == StSpurious || rsp_o.status == StEmptyWord)
    else $error("more_pending disagrees with summary");

  a_spurious_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && act_q == ActClaim && summary_q == '0 |=> rsp_o.status == StSpurious)
    else $error("claim on empty summary not reported spurious");

  a_found_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.found |-> rsp_o.status == StOk)
    else $error("found beat carries an error status");

endmodule

/* tb/two_level_pending_irq_picker_tb.sv */
module two_level_pending_irq_picker_tb import irqpk_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Groups = 16;
  localparam int unsigned GrpW   = VecW - BitW;
  localparam int unsigned ItemsPerPhase = 350;

  typedef struct packed {
    logic            found;
    logic [VecW-1:0] vec_out;
    logic            more;
    status_e         status;
  } outcome_t;

  // mirror of the pending bitmap, holds the outcomes still owed by the block
  class pending_irq_mirror;
    logic [Groups-1:0] summary;
    word_t             words [Groups];
    logic [LimitW-1:0] limit;
    outcome_t          outcomes [$];
    int unsigned       errors;

    function new();
      summary = '0;
      foreach (words[g]) words[g] = '0;
      limit = LimitReset;
      errors = 0;
    endfunction

    function int unsigned lowest_one(word_t v);
      int unsigned n = 0;
      while (n < WordBits - 1 && !v[n]) n++;
      return n;
    endfunction

    function void note_beat(logic act, logic [VecW-1:0] vec);
      outcome_t        o;
      logic [GrpW-1:0] grp;
      logic [BitW-1:0] bitn;
      logic [VecW-1:0] claimed;
      o = '{found: 1'b0, vec_out: '0, more: 1'b0, status: StOk};
      if (act == ActRaise) begin
        grp = vec[VecW-1:BitW];
        words[grp][vec[BitW-1:0]] = 1'b1;
        summary[grp] = 1'b1;
      end else if (summary == '0) begin
        o.status = StSpurious;
      end else begin
        grp = GrpW'(lowest_one(word_t'(summary)));
        if (words[grp] == '0) begin
          o.status = StEmptyWord;
        end else begin
          bitn = BitW'(lowest_one(words[grp]));
          claimed = {grp, bitn};
          words[grp][bitn] = 1'b0;
          if (words[grp] == '0) summary[grp] = 1'b0;
          o.more = |summary;
          if (LimitW'(claimed) >= limit) begin
            o.status = StOverLimit;
          end else begin
            o.found = 1'b1;
            o.vec_out = claimed;
          end
        end
      end
      outcomes.push_back(o);
    endfunction

    function void check_beat(logic found, logic [VecW-1:0] vec, logic more, status_e st);
      outcome_t o;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: found %0b vector %0d status %0d",
                 $time, found, vec, st);
        return;
      end
      o = outcomes.pop_front();
      if (found !== o.found) begin
        errors++;
        $display("%0t: found expected %0b actual %0b", $time, o.found, found);
      end
      if (vec !== o.vec_out) begin
        errors++;
        $display("%0t: vector_out expected %0d actual %0d", $time, o.vec_out, vec);
      end
      if (more !== o.more) begin
        errors++;
        $display("%0t: more_pending expected %0b actual %0b", $time, o.more, more);
      end
      if (st !== o.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, o.status, st);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;

  irqpk_req_if req_if ();
  irqpk_rsp_if rsp_if ();

  pending_irq_mirror mirror;
  int unsigned       burst_left;

  two_level_pending_irq_picker #(
    .GROUPS (Groups)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stall patterns
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned k;
    mode = 0;
    left = 0;
    k = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      k++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        2: rsp_if.ready <= (k % 5) < 2;
        default: rsp_if.ready <= (k % 12) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      mirror.check_beat(rsp_if.found, rsp_if.vector_out, rsp_if.more_pending, rsp_if.status);
    end
  end

  task automatic send_beat(logic act, logic [VecW-1:0] vec);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.vector_in <= vec;
    do @(posedge clk_i); while (!req_if.ready);
    mirror.note_beat(act, vec);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (mirror.outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.limit = value;
  endtask

  task automatic run_random(int unsigned count);
    int unsigned     done;
    int unsigned     mode;
    int unsigned     len;
    logic [GrpW-1:0] grp;
    logic [VecW-1:0] vec;
    done = 0;
    while (done < count) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(1, 24);
      grp  = GrpW'($urandom_range(0, Groups - 1));
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0, 1: vec = {grp, BitW'($urandom_range(0, WordBits - 1))};
          2: vec = VecW'($urandom_range(0, (1 << VecW) - 1));
          default: begin
            case ($urandom_range(0, 3))
              0: vec = {grp, {BitW{1'b0}}};
              1: vec = {grp, {BitW{1'b1}}};
              2: vec = '0;
              default: vec = '1;
            endcase
          end
        endcase
        case (mode)
          0: send_beat(($urandom_range(0, 7) == 0) ? ActClaim : ActRaise, vec);
          1: send_beat(($urandom_range(0, 7) == 0) ? ActRaise : ActClaim, vec);
          default: send_beat(1'($urandom_range(0, 1)), vec);
        endcase
      end
      done += len;
    end
  endtask

  initial begin
    mirror     = new();
    burst_left = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.action    <= ActRaise;
    req_if.vector_in <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing pending, then a spread of raises drained in order
    send_beat(ActClaim, 9'd511);
    send_beat(ActRaise, 9'd511);
    send_beat(ActRaise, 9'd0);
    send_beat(ActRaise, 9'd0);
    send_beat(ActRaise, 9'd31);
    send_beat(ActRaise, 9'd32);
    send_beat(ActRaise, 9'd480);
    repeat (6) send_beat(ActClaim, 9'd0);

    // limit at zero: every claim is over the limit, spurious still wins
    write_limit('0);
    send_beat(ActRaise, 9'd5);
    send_beat(ActRaise, 9'd7);
    send_beat(ActClaim, 9'd0);
    send_beat(ActClaim, 9'd0);
    send_beat(ActClaim, 9'd0);

    // limit right at a pending vector
    write_limit(12'd40);
    send_beat(ActRaise, 9'd40);
    send_beat(ActRaise, 9'd39);
    send_beat(ActClaim, 9'd0);
    send_beat(ActClaim, 9'd0);

    write_limit(LimitReset);
    run_random(ItemsPerPhase);
    write_limit('1);
    run_random(ItemsPerPhase);
    write_limit('0);
    run_random(ItemsPerPhase);
    write_limit(LimitW'($urandom_range(1, 511)));
    run_random(ItemsPerPhase);
    write_limit(12'd300);
    run_random(ItemsPerPhase);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
